@@ hw/rtl/indexed_list_insert_remove_core_defines.svh @@
// Assertion macros shared by the indexed list core.
// The including module must provide signals named clk and rst.
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ILIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ilir_pkg.sv @@
// Package for the indexed list core: request, status and command codes.
// No dependencies.
package ilir_pkg;

  // Request kinds carried on the action field.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_WRITE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Datapath storage operations.
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_WRITE  = 2'd3;

  // Fixed field widths of the channels.
  localparam int POS_BITS  = 5;
  localparam int DATA_BITS = 32;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic       load;     // capture a result beat this cycle
    logic [1:0] op;       // storage operation
    logic [1:0] status;   // status code of the result
    logic       ret_data; // return the addressed word
  } cmd_t;

endpackage

@@ hw/rtl/ilir_req_if.sv @@
// Request channel of the indexed list core: valid/ready plus payload.
// Depends on ilir_pkg for field widths.
interface ilir_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [ilir_pkg::POS_BITS-1:0]        position;
  logic signed [ilir_pkg::DATA_BITS-1:0] value;

  modport source (output valid, output action, output position, output value,
                  input ready);
  modport sink (input valid, input action, input position, input value,
                output ready);
endinterface

@@ hw/rtl/ilir_rsp_if.sv @@
// Result channel of the indexed list core: valid/ready plus payload.
// Depends on ilir_pkg for field widths.
interface ilir_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ilir_pkg::DATA_BITS-1:0] data_out;
  logic [1:0]                           status;
  logic [ilir_pkg::POS_BITS-1:0]        count;

  modport source (output valid, output data_out, output status, output count,
                  input ready);
  modport sink (input valid, input data_out, input status, input count,
                output ready);
endinterface

@@ hw/rtl/ilir_ctrl.sv @@
// Controller of the indexed list core: handshake state machine and request checks.
// Depends on ilir_pkg.
module ilir_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CNT_BITS = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    action,
  input  logic [ilir_pkg::POS_BITS-1:0] position,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  logic [CNT_BITS-1:0]           count,
  output ilir_pkg::cmd_t                cmd
);

  localparam int CMPW = (CNT_BITS > ilir_pkg::POS_BITS) ? CNT_BITS : ilir_pkg::POS_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic            state;
  logic            state_next;
  logic            accept;
  logic [CMPW-1:0] pos_e;
  logic [CMPW-1:0] cnt_e;

  // A new beat is taken when the result register is empty or being drained.
  assign req_ready = (state == ST_IDLE) || rsp_ready;
  assign rsp_valid = (state == ST_HOLD);
  assign accept    = req_valid && req_ready;

  // The result register stays full while beats keep arriving.
  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = ST_HOLD;
    end else if (rsp_ready) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Check the position against the fill level and pick the storage operation.
  assign pos_e = CMPW'(position);
  assign cnt_e = CMPW'(count);

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.op       = ilir_pkg::OP_NONE;
    cmd.status   = ilir_pkg::STAT_OK;
    cmd.ret_data = 1'b0;
    if (action == ilir_pkg::ACT_INSERT) begin
      if (pos_e > cnt_e) begin
        cmd.status = ilir_pkg::STAT_RANGE;
      end else if (cnt_e >= CMPW'(CAPACITY)) begin
        cmd.status = ilir_pkg::STAT_FULL;
      end else begin
        cmd.op = accept ? ilir_pkg::OP_INSERT : ilir_pkg::OP_NONE;
      end
    end else begin
      if (pos_e >= cnt_e) begin
        cmd.status = ilir_pkg::STAT_RANGE;
      end else begin
        cmd.ret_data = 1'b1;
        unique case (action)
          ilir_pkg::ACT_REMOVE: cmd.op = accept ? ilir_pkg::OP_REMOVE : ilir_pkg::OP_NONE;
          ilir_pkg::ACT_WRITE:  cmd.op = accept ? ilir_pkg::OP_WRITE : ilir_pkg::OP_NONE;
          default:              cmd.op = ilir_pkg::OP_NONE;
        endcase
      end
    end
  end

endmodule

@@ hw/rtl/ilir_datapath.sv @@
// Datapath of the indexed list core: shifting entry cells, fill count, result register.
// Depends on ilir_pkg.
module ilir_datapath #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32,
  parameter int CNT_BITS  = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ilir_pkg::cmd_t                        cmd,
  input  logic [ilir_pkg::POS_BITS-1:0]         position,
  input  logic signed [ilir_pkg::DATA_BITS-1:0] value,
  output logic [CNT_BITS-1:0]                   count,
  output logic signed [ilir_pkg::DATA_BITS-1:0] data_out,
  output logic [1:0]                            status,
  output logic [ilir_pkg::POS_BITS-1:0]         count_out
);

  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW     = (CNT_BITS > ilir_pkg::POS_BITS) ? CNT_BITS : ilir_pkg::POS_BITS;
  localparam int DW       = ilir_pkg::DATA_BITS;

  logic [WORD_BITS-1:0] entries [CAPACITY];
  logic [WORD_BITS-1:0] wr_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [DW-1:0]        rd_ext;
  logic [CMPW-1:0]      pos_e;
  logic [CMPW-1:0]      cnt_e;
  logic [CNT_BITS-1:0]  count_next;

  assign pos_e = CMPW'(position);
  assign cnt_e = CMPW'(count_next);

  // Fit the 32-bit request word to the stored word width.
  generate
    if (WORD_BITS <= DW) begin : g_wr_narrow
      assign wr_word = value[WORD_BITS-1:0];
    end else begin : g_wr_wide
      assign wr_word = {{(WORD_BITS-DW){value[DW-1]}}, value};
    end
  endgenerate

  // Read the addressed entry and sign-extend it to the result width.
  assign rd_word = entries[pos_e[IDX_BITS-1:0]];

  generate
    if (WORD_BITS >= DW) begin : g_rd_wide
      assign rd_ext = rd_word[DW-1:0];
    end else begin : g_rd_narrow
      assign rd_ext = {{(DW-WORD_BITS){rd_word[WORD_BITS-1]}}, rd_word};
    end
  endgenerate

  // Each cell compares its slot with the position and loads its neighbor or the new word.
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [WORD_BITS-1:0] lower;
      logic [WORD_BITS-1:0] upper;
      logic [WORD_BITS-1:0] cell_next;
      logic [CMPW-1:0]      slot;

      assign slot = CMPW'(gi);

      if (gi == 0) begin : g_lo_edge
        assign lower = wr_word;
      end else begin : g_lo_mid
        assign lower = entries[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_hi_edge
        assign upper = entries[gi];
      end else begin : g_hi_mid
        assign upper = entries[gi+1];
      end

      always_comb begin
        cell_next = entries[gi];
        unique case (cmd.op)
          ilir_pkg::OP_INSERT: begin
            if (slot > pos_e) begin
              cell_next = lower;
            end else if (slot == pos_e) begin
              cell_next = wr_word;
            end
          end
          ilir_pkg::OP_REMOVE: begin
            if (slot >= pos_e) begin
              cell_next = upper;
            end
          end
          ilir_pkg::OP_WRITE: begin
            if (slot == pos_e) begin
              cell_next = wr_word;
            end
          end
          default: cell_next = entries[gi];
        endcase
      end

      always_ff @(posedge clk) begin
        entries[gi] <= cell_next;
      end
    end
  endgenerate

  // Fill count follows inserts and removes.
  always_comb begin
    count_next = count;
    unique case (cmd.op)
      ilir_pkg::OP_INSERT: count_next = count + CNT_BITS'(1);
      ilir_pkg::OP_REMOVE: count_next = count - CNT_BITS'(1);
      default:             count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register, loaded once per accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_out  <= cmd.ret_data ? rd_ext : '0;
      status    <= cmd.status;
      count_out <= cnt_e[ilir_pkg::POS_BITS-1:0];
    end
  end

endmodule

@@ hw/rtl/indexed_list_insert_remove_core.sv @@
// Indexed list core: an ordered list of up to CAPACITY signed words with insert and remove
// at any position, read, and write. Every request beat gives exactly one result beat. The
// whole update, including the shift of all later entries, happens in the cycle the request
// is accepted, since every entry cell compares its slot with the position and loads from a
// neighbor in parallel; the result appears in the next cycle in an output register, and a new
// request is taken in every cycle in which that register is empty or being drained, so the
// rate is one request per cycle. Entries beyond the fill count are not cleared and hold
// undefined data until written. Depends on ilir_pkg, the channel interfaces, ilir_ctrl,
// ilir_datapath and the assertion macro header.
`include "indexed_list_insert_remove_core_defines.svh"

module indexed_list_insert_remove_core #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  ilir_req_if.sink   req,
  ilir_rsp_if.source rsp
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  ilir_pkg::cmd_t      cmd;
  logic [CNT_BITS-1:0] count;
  logic                rsp_error;
  logic                rsp_full;

  // Controller: handshake and request checks.
  ilir_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_BITS (CNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .action    (req.action),
    .position  (req.position),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .count     (count),
    .cmd       (cmd)
  );

  // Datapath: entry cells, fill count and result register.
  ilir_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS),
    .CNT_BITS  (CNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .position  (req.position),
    .value     (req.value),
    .count     (count),
    .data_out  (rsp.data_out),
    .status    (rsp.status),
    .count_out (rsp.count)
  );

  // Result beats that report an error, and those that report a full list.
  assign rsp_error = rsp.valid && (rsp.status != ilir_pkg::STAT_OK);
  assign rsp_full  = rsp.valid && (rsp.status == ilir_pkg::STAT_FULL);

  // The fill level never exceeds the capacity.
  `ILIR_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_BITS'(CAPACITY), "fill count above capacity")

  // An accepted request always leaves a result beat behind it.
  `ILIR_ASSERT_NEXT(a_result_follows, req.valid && req.ready, rsp.valid, "result beat missing")

  // A failed request returns no data.
  `ILIR_ASSERT_NOW(a_error_zero, rsp_error, rsp.data_out == '0, "data on error beat")

  // A full report only comes with a full list.
  `ILIR_ASSERT_NOW(a_full_count, rsp_full, count == CNT_BITS'(CAPACITY), "full status with room left")

endmodule

@@ sim/indexed_list_insert_remove_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking test of the indexed list core: insert, remove, read and write beats.
// A list model predicts every reply beat, which is compared field by field as it arrives.
// Depends on ilir_pkg, ilir_req_if, ilir_rsp_if and indexed_list_insert_remove_core.
module indexed_list_insert_remove_core_test;

  localparam int CAPACITY = 16;
  localparam int WORD_BITS = 32;

  typedef logic [1:0] action_t;
  typedef logic [ilir_pkg::POS_BITS-1:0] position_t;
  typedef logic signed [ilir_pkg::DATA_BITS-1:0] word_t;

  // One reply beat as it should appear on the result channel.
  typedef struct packed {
    word_t     data_out;
    logic [1:0] status;
    position_t count;
  } list_reply_t;

  logic clk;
  logic rst;

  ilir_req_if req_ch ();
  ilir_rsp_if rsp_ch ();

  indexed_list_insert_remove_core #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(WORD_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // List model: the words held and how many of them there are.
  word_t list_words [CAPACITY];
  int list_len;

  list_reply_t predicted_replies [$];
  int error_count;

  // Idle controls, changed between phases of the stimulus.
  bit gaps_on;
  bit stalls_on;

  // Clock: 8 ns period.
  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle length: mostly short, now and then long.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 12);
    return $urandom_range(20, 40);
  endfunction

  // Random word with the extremes mixed in.
  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'h00000000;
      default: return $urandom;
    endcase
  endfunction

  // Position that the current list accepts for the given action; 0 for a non-insert on an empty list.
  function automatic position_t valid_position(action_t act);
    int top;
    top = (act == ilir_pkg::ACT_INSERT) ? list_len : list_len - 1;
    if (top < 0) top = 0;
    return position_t'($urandom_range(0, top));
  endfunction

  // Apply one accepted request to the list model and queue its reply.
  function automatic void model_list_request(action_t act, position_t pos, word_t val);
    list_reply_t reply;
    int i;
    reply.data_out = '0;
    reply.status = ilir_pkg::STAT_OK;
    if (act == ilir_pkg::ACT_INSERT) begin
      if (pos > list_len) begin
        reply.status = ilir_pkg::STAT_RANGE;
      end else if (list_len >= CAPACITY) begin
        reply.status = ilir_pkg::STAT_FULL;
      end else begin
        for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
        list_words[pos] = val;
        list_len++;
      end
    end else if (pos >= list_len) begin
      reply.status = ilir_pkg::STAT_RANGE;
    end else begin
      reply.data_out = list_words[pos];
      if (act == ilir_pkg::ACT_REMOVE) begin
        for (i = pos + 1; i < list_len; i++) list_words[i-1] = list_words[i];
        list_words[list_len-1] = '0;
        list_len--;
      end else if (act == ilir_pkg::ACT_WRITE) begin
        list_words[pos] = val;
      end
    end
    reply.count = list_len[ilir_pkg::POS_BITS-1:0];
    predicted_replies.push_back(reply);
  endfunction

  // Send one request beat, with an optional gap first; the model is updated on acceptance.
  task automatic send_request(action_t act, position_t pos, word_t val);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.action = act;
    req_ch.position = pos;
    req_ch.value = val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    model_list_request(act, pos, val);
  endtask

  // Reply side: random stalls while enabled, otherwise always ready.
  initial begin : reply_stalls
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_idle_len();
      end
    end
  end

  // Compare each reply beat with the oldest prediction.
  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: reply beat with none predicted: data_out %0d status %0d count %0d",
                 $time, rsp_ch.data_out, rsp_ch.status, rsp_ch.count);
        error_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (rsp_ch.data_out !== want.data_out) begin
          $display("%0t: data_out mismatch: expected %0d, actual %0d",
                   $time, want.data_out, rsp_ch.data_out);
          error_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.count !== want.count) begin
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, want.count, rsp_ch.count);
          error_count++;
        end
      end
    end
  end

  // Edges of the list: empty-list errors, extreme words, middle and last removal,
  // positions far out of range.
  task automatic test_directed_edges();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_request(ilir_pkg::ACT_READ, 5'd0, 32'sd5);
    send_request(ilir_pkg::ACT_REMOVE, 5'd0, 32'sd0);
    send_request(ilir_pkg::ACT_WRITE, 5'd0, 32'sd1);
    send_request(ilir_pkg::ACT_INSERT, 5'd1, 32'sd7);
    send_request(ilir_pkg::ACT_INSERT, 5'd0, 32'h7fffffff);
    send_request(ilir_pkg::ACT_INSERT, 5'd1, 32'h80000000);
    send_request(ilir_pkg::ACT_INSERT, 5'd1, -32'sd1);
    send_request(ilir_pkg::ACT_INSERT, 5'd0, 32'sd0);
    for (int p = 0; p < 4; p++) send_request(ilir_pkg::ACT_READ, position_t'(p), 32'hffffffff);
    send_request(ilir_pkg::ACT_WRITE, 5'd3, 32'h55555555);
    send_request(ilir_pkg::ACT_WRITE, 5'd0, 32'haaaaaaaa);
    send_request(ilir_pkg::ACT_REMOVE, 5'd1, 32'sd0);
    send_request(ilir_pkg::ACT_REMOVE, position_t'(list_len - 1), 32'sd0);
    send_request(ilir_pkg::ACT_READ, 5'd31, 32'sd0);
    send_request(ilir_pkg::ACT_INSERT, 5'd31, 32'sd3);
    send_request(ilir_pkg::ACT_WRITE, 5'd16, 32'sd4);
    send_request(ilir_pkg::ACT_REMOVE, 5'd0, 32'sd0);
    send_request(ilir_pkg::ACT_REMOVE, 5'd0, 32'sd0);
  endtask

  // Fill the list completely, probe the full cases, then drain it.
  task automatic test_fill_to_capacity();
    for (int pass = 0; pass < 3; pass++) begin
      gaps_on = pass[0];
      stalls_on = (pass != 0);
      while (list_len < CAPACITY) send_request(ilir_pkg::ACT_INSERT,
                                               valid_position(ilir_pkg::ACT_INSERT),
                                               random_word());
      // Insert into a full list, with the position check taking precedence.
      send_request(ilir_pkg::ACT_INSERT, position_t'(CAPACITY), random_word());
      send_request(ilir_pkg::ACT_INSERT, 5'd0, random_word());
      send_request(ilir_pkg::ACT_INSERT, position_t'(CAPACITY + 1), random_word());
      send_request(ilir_pkg::ACT_READ, position_t'(CAPACITY - 1), random_word());
      send_request(ilir_pkg::ACT_WRITE, position_t'($urandom_range(0, CAPACITY - 1)),
                   random_word());
      send_request(ilir_pkg::ACT_REMOVE, position_t'(CAPACITY), random_word());
      while (list_len > 0) send_request(ilir_pkg::ACT_REMOVE,
                                        valid_position(ilir_pkg::ACT_REMOVE),
                                        random_word());
    end
  endtask

  // Random mix of all actions, with phases that lean toward filling or draining.
  task automatic test_random_mix(int n_items);
    int ins_pct;
    int rem_pct;
    int r;
    action_t act;
    position_t pos;
    ins_pct = 30;
    rem_pct = 30;
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) begin
        gaps_on = bit'($urandom_range(0, 1));
        stalls_on = bit'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
          0: begin ins_pct = 45; rem_pct = 15; end
          1: begin ins_pct = 15; rem_pct = 45; end
          default: begin ins_pct = 30; rem_pct = 30; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < ins_pct) act = ilir_pkg::ACT_INSERT;
      else if (r < ins_pct + rem_pct) act = ilir_pkg::ACT_REMOVE;
      else if (r < ins_pct + rem_pct + 20) act = ilir_pkg::ACT_READ;
      else act = ilir_pkg::ACT_WRITE;
      // Mostly positions the list accepts, some anywhere in the field.
      if ($urandom_range(0, 99) < 85) pos = valid_position(act);
      else pos = position_t'($urandom_range(0, 31));
      send_request(act, pos, random_word());
    end
  endtask

  // Wait for every predicted reply, let the pipeline settle, then report.
  task automatic finish_run();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (predicted_replies.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ilir_pkg::ACT_INSERT;
    req_ch.position = '0;
    req_ch.value = '0;
    list_len = 0;
    error_count = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < CAPACITY; i++) list_words[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_edges();
    test_fill_to_capacity();
    test_random_mix(1400);
    finish_run();
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
